[hdl/fpst_pkg.sv]
// Shared constants and types for the Fenwick prefix-sum table.
`default_nettype none
package fpst_pkg;
	localparam int TABLE_DEPTH = 1024;
	localparam int POS_W = 10;
	localparam int WORD_W = 32;
	// node store address width
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	// tree node width: holds position+1 and the upward step past the top
	localparam int NODE_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [NODE_W-1:0] node_t;

	localparam logic ACT_QUERY = 1'b0;
	localparam logic ACT_ADD = 1'b1;
endpackage
`default_nettype wire

[hdl/fpst_if.sv]
// Request and response stream interfaces of the Fenwick prefix-sum table.
`default_nettype none
interface fpst_req_if;
	logic valid;
	logic ready;
	logic action;
	fpst_pkg::pos_t position;
	fpst_pkg::word_t delta;

	modport source (output valid, output action, output position, output delta, input ready);
	modport sink (input valid, input action, input position, input delta, output ready);
endinterface

interface fpst_rsp_if;
	logic valid;
	logic ready;
	fpst_pkg::word_t prefix_total;
	logic range_error;

	modport source (output valid, output prefix_total, output range_error, input ready);
	modport sink (input valid, input prefix_total, input range_error, output ready);
endinterface
`default_nettype wire

[hdl/fenwick_prefix_sum_table.sv]
// Fenwick prefix-sum table: node store, walk sequencer and response register.
//
// channel  dir  word
// req      in   action, position, delta
// rsp      out  prefix_total, range_error (queries and out-of-range requests only)
//
// After reset a clearing pass writes zero to all TABLE_DEPTH node words, one a
// cycle; req is not ready during it.
// A request walks its node chain one node a cycle through the single-port read
// of the node store and one shared 32-bit adder; a chain holds at most
// log2(TABLE_DEPTH) nodes, and a query then loads the response register.
// The response register lets the next request in while a response waits on rsp.
`default_nettype none
module fenwick_prefix_sum_table (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fpst_req_if.sink     req,
	fpst_rsp_if.source   rsp
);
	import fpst_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	idx_t   clr_q, clr_d;
	node_t  node_q, node_d;
	logic   action_q, action_d;
	word_t  delta_q, delta_d;
	word_t  acc_q, acc_d;
	logic   err_q, err_d;

	logic   out_valid_q;
	word_t  out_total_q;
	logic   out_err_q;
	logic   out_load;

	// node store
	word_t  mem [TABLE_DEPTH];
	word_t  rdata_q;
	idx_t   rd_addr;
	logic   mem_we;
	idx_t   mem_wa;
	word_t  mem_wd;

	node_t  node_in;
	node_t  low_bit;
	node_t  node_up;
	node_t  node_dn;
	word_t  sum_w;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[rd_addr];
	end

	assign node_in = node_t'(req.position) + node_t'(1);
	assign low_bit = node_q & (~node_q + node_t'(1));
	assign node_up = node_q + low_bit;
	assign node_dn = node_q - low_bit;
	// one adder serves both walks
	assign sum_w = rdata_q + ((action_q == ACT_ADD) ? delta_q : acc_q);

	assign req.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		node_d   = node_q;
		action_d = action_q;
		delta_d  = delta_q;
		acc_d    = acc_q;
		err_d    = err_q;
		rd_addr  = node_q[IDX_W-1:0];
		mem_we   = 1'b0;
		mem_wa   = node_q[IDX_W-1:0];
		mem_wd   = sum_w;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
				clr_d  = clr_q + idx_t'(1);
				if (clr_q == idx_t'(TABLE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				rd_addr = node_in[IDX_W-1:0];
				if (req.valid) begin
					action_d = req.action;
					delta_d  = req.delta;
					acc_d    = '0;
					node_d   = node_in;
					if (node_in >= node_t'(TABLE_DEPTH)) begin
						err_d   = 1'b1;
						state_d = ST_FIN;
					end else begin
						err_d   = 1'b0;
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (action_q == ACT_ADD) begin
					mem_we = 1'b1;
					if (node_up < node_t'(TABLE_DEPTH)) begin
						node_d  = node_up;
						rd_addr = node_up[IDX_W-1:0];
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					acc_d = sum_w;
					if (node_dn == '0) begin
						state_d = ST_FIN;
					end else begin
						node_d  = node_dn;
						rd_addr = node_dn[IDX_W-1:0];
					end
				end
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		node_q   <= node_d;
		action_q <= action_d;
		delta_q  <= delta_d;
		acc_q    <= acc_d;
		err_q    <= err_d;
		if (out_load) begin
			out_total_q <= acc_q;
			out_err_q   <= err_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.prefix_total = out_total_q;
	assign rsp.range_error  = out_err_q;
endmodule
`default_nettype wire

[test/fenwick_prefix_sum_table_tb.sv]
// Self-checking testbench for the Fenwick prefix-sum table: point adds, prefix queries, range errors.
module fenwick_prefix_sum_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fpst_pkg::*;

	typedef struct {
		logic  action;
		pos_t  position;
		word_t delta;
		int    gap;
		logic  drain;
		int    phase;
	} table_request_t;

	typedef struct {
		word_t total;
		logic  range_error;
	} prefix_result_t;

	localparam int STALL_PHASES = 3;
	localparam int MAX_GAP = 16;
	localparam int TAIL_CYCLES = 24;

	// idle percentages per phase: sender light/heavy/none, receiver the other way
	int send_idle_pct [STALL_PHASES] = '{8, 55, 0};
	int recv_stall_pct [STALL_PHASES] = '{55, 8, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fpst_req_if req_ch ();
	fpst_rsp_if rsp_ch ();

	fenwick_prefix_sum_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	table_request_t pending_reqs [$];
	prefix_result_t expected_totals [$];
	logic [WORD_W-1:0] node_mirror [TABLE_DEPTH];

	table_request_t next_req;
	int gap_cnt;
	int rsp_stall_pct;
	logic rsp_drained;

	int errors = 0;
	int n_queries = 0;
	int n_adds = 0;
	int n_range = 0;
	int n_checked = 0;

	task automatic queue_request(input logic act, input pos_t pos, input word_t dlt,
			input int phase, input logic drain);
		table_request_t r;
		r.action = act;
		r.position = pos;
		r.delta = dlt;
		r.phase = phase;
		r.drain = drain;
		r.gap = 0;
		while (r.gap < MAX_GAP && $urandom_range(99) < send_idle_pct[phase[1:0]])
			r.gap++;
		pending_reqs = {pending_reqs, r};
	endtask

	// walk the mirror tree exactly as the block should
	task automatic predict_request(input logic act, input pos_t pos, input word_t dlt);
		int unsigned node;
		logic [WORD_W-1:0] acc;
		prefix_result_t res;
		node = pos + 1;
		if (node >= TABLE_DEPTH) begin
			res.total = '0;
			res.range_error = 1'b1;
			expected_totals = {expected_totals, res};
			n_range++;
			return;
		end
		if (act == ACT_ADD) begin
			while (node < TABLE_DEPTH) begin
				node_mirror[node[IDX_W-1:0]] += dlt;
				node += node & (~node + 1);
			end
			n_adds++;
		end else begin
			acc = '0;
			while (node > 0) begin
				acc += node_mirror[node[IDX_W-1:0]];
				node -= node & (~node + 1);
			end
			res.total = acc;
			res.range_error = 1'b0;
			expected_totals = {expected_totals, res};
			n_queries++;
		end
	endtask

	task automatic check_response();
		prefix_result_t want;
		if (expected_totals.size() == 0) begin
			$display("%0t: unexpected response prefix_total=%0d range_error=%0b",
				$time, rsp_ch.prefix_total, rsp_ch.range_error);
			errors++;
			return;
		end
		want = expected_totals.pop_front();
		if (rsp_ch.prefix_total !== want.total) begin
			$display("%0t: prefix_total mismatch: expected %0d actual %0d",
				$time, want.total, rsp_ch.prefix_total);
			errors++;
		end
		if (rsp_ch.range_error !== want.range_error) begin
			$display("%0t: range_error mismatch: expected %0b actual %0b",
				$time, want.range_error, rsp_ch.range_error);
			errors++;
		end
		n_checked++;
	endtask

	// driver: holds a word until taken, then honours gaps and drain pauses
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.action <= ACT_QUERY;
			req_ch.position <= '0;
			req_ch.delta <= '0;
			gap_cnt <= 0;
			rsp_stall_pct <= 0;
		end else if (req_ch.valid && !req_ch.ready) begin
			// word still on offer
		end else if (pending_reqs.size() == 0) begin
			req_ch.valid <= 1'b0;
		end else if (gap_cnt < pending_reqs[0].gap ||
				(pending_reqs[0].drain && (req_ch.valid || !rsp_drained))) begin
			req_ch.valid <= 1'b0;
			if (gap_cnt < pending_reqs[0].gap)
				gap_cnt <= gap_cnt + 1;
		end else begin
			next_req = pending_reqs.pop_front();
			req_ch.valid <= 1'b1;
			req_ch.action <= next_req.action;
			req_ch.position <= next_req.position;
			req_ch.delta <= next_req.delta;
			gap_cnt <= 0;
			rsp_stall_pct <= recv_stall_pct[next_req.phase[1:0]];
		end
	end

	// monitor: predicts on request acceptance, checks on response acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_drained <= 1'b1;
			expected_totals.delete();
			node_mirror = '{default: '0};
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
			if (rsp_ch.valid && rsp_ch.ready)
				check_response();
			if (req_ch.valid && req_ch.ready)
				predict_request(req_ch.action, req_ch.position, req_ch.delta);
			rsp_drained <= (expected_totals.size() == 0);
		end
	end

	initial begin
		int phase;
		int pick;
		pos_t pos;
		word_t dlt;

		// directed: empty table, range errors, wrapping, chain boundaries
		queue_request(ACT_QUERY, 10'd0, 32'sd0, 0, 1'b0);
		queue_request(ACT_QUERY, 10'd1022, 32'sd0, 0, 1'b0);
		queue_request(ACT_QUERY, 10'd1023, 32'sd0, 0, 1'b0);
		queue_request(ACT_ADD, 10'd1023, 32'sd5, 0, 1'b0);
		queue_request(ACT_ADD, 10'd0, 32'h7FFF_FFFF, 0, 1'b0);
		queue_request(ACT_ADD, 10'd0, 32'sd1, 0, 1'b0);
		queue_request(ACT_QUERY, 10'd0, 32'sd0, 0, 1'b0);
		queue_request(ACT_ADD, 10'd1022, 32'h8000_0000, 0, 1'b0);
		queue_request(ACT_QUERY, 10'd1022, 32'sd0, 0, 1'b0);
		queue_request(ACT_ADD, 10'd511, -32'sd1, 0, 1'b0);
		queue_request(ACT_ADD, 10'd255, 32'sd12345, 0, 1'b0);
		queue_request(ACT_QUERY, 10'd511, 32'sd0, 0, 1'b0);
		queue_request(ACT_QUERY, 10'd510, 32'sd0, 0, 1'b0);
		queue_request(ACT_QUERY, 10'd255, 32'sd0, 0, 1'b0);
		queue_request(ACT_QUERY, 10'd256, 32'sd0, 0, 1'b0);
		queue_request(ACT_ADD, 10'd1023, -32'sd1, 0, 1'b0);
		queue_request(ACT_QUERY, 10'd1023, 32'hFFFF_FFFF, 0, 1'b0);
		queue_request(ACT_ADD, 10'd1, 32'hFFFF_FFFF, 0, 1'b0);
		queue_request(ACT_QUERY, 10'd1, 32'h5555_AAAA, 0, 1'b0);
		queue_request(ACT_ADD, 10'd767, 32'h8000_0000, 0, 1'b1);
		queue_request(ACT_QUERY, 10'd1021, 32'sd0, 0, 1'b0);
		queue_request(ACT_QUERY, 10'd767, 32'sd0, 0, 1'b0);

		for (int n = 0; n < 600; n++) begin
			phase = n / 200;
			pick = $urandom_range(99);
			if (pick < 5)
				pos = 10'd1023;
			else if (pick < 15)
				pos = pos_t'($urandom_range(15));
			else
				pos = pos_t'($urandom_range(1022));
			case ($urandom_range(3))
				0: begin
					dlt = $signed($urandom_range(200)) - 32'sd100;
				end
				1: begin
					case ($urandom_range(3))
						0: dlt = 32'h7FFF_FFFF;
						1: dlt = 32'h8000_0000;
						2: dlt = -32'sd1;
						default: dlt = 32'sd0;
					endcase
				end
				default: begin
					dlt = $urandom();
				end
			endcase
			queue_request($urandom_range(1) ? ACT_ADD : ACT_QUERY, pos, dlt, phase,
				n == 150 || n == 420);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (pending_reqs.size() != 0 || req_ch.valid);
		do @(negedge clk); while (!rsp_drained);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (expected_totals.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, expected_totals.size());
			errors++;
		end

		$display("Run covered %0d prefix queries, %0d point adds and %0d out-of-range words,",
			n_queries, n_adds, n_range);
		$display("across three idle/stall mixes with drain pauses; %0d responses checked.",
			n_checked);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// clearing pass plus ~650 slow words under heavy stalls fits well inside this
	initial begin
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("Some tests failed");
		$finish;
	end
endmodule

[sim.f]
hdl/fpst_pkg.sv
hdl/fpst_if.sv
hdl/fenwick_prefix_sum_table.sv
test/fenwick_prefix_sum_table_tb.sv
